// ----- rtl/orse_pkg.sv -----
// Shared types, codes and the CRC-8 step for the 1-Wire search ROM engine.
package orse_pkg;

  // Request codes on in_func
  localparam logic [1:0] FUNC_START      = 2'd0;
  localparam logic [1:0] FUNC_RESET_DONE = 2'd1;
  localparam logic [1:0] FUNC_BIT_PAIR   = 2'd2;

  // Search phase codes (code 3 is never written and acts as idle)
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RESET = 2'd1;
  localparam logic [1:0] PH_BITS  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_NO_DEV   = 3'd2;
  localparam logic [2:0] ST_NO_RESP  = 3'd3;
  localparam logic [2:0] ST_CRC_FAIL = 3'd4;

  // Register indexes
  localparam logic REG_MAX_ROMS    = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  localparam logic [7:0] NO_COLL     = 8'd255;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam logic [5:0] CRC_END_POS = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [7:0] MAX_ROMS_RST    = 8'd255;
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [5:0]  bit_pos;
    logic [7:0]  prev_coll;
    logic [7:0]  last_coll;
    logic [63:0] cur_rom;
    logic [63:0] prev_rom;
    logic        have_prev;
    logic [7:0]  attempts;
    logic [7:0]  found;
    logic [7:0]  crc;
  } search_state_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_bit;
    logic        issue_reset;
    logic        rom_valid;
    logic [63:0] rom_id;
    logic [7:0]  rom_number;
    logic [2:0]  status;
    logic        done_res;
  } result_t;

  // Dallas CRC-8, one bit, LSB first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic b);
    logic [7:0] r;
    r = {1'b0, crc[7:1]};
    if (crc[0] ^ b) begin
      r = r ^ CRC_POLY;
    end
    return r;
  endfunction

endpackage

// ----- rtl/orse_core.sv -----
// Next-state and result logic for one search request or bit slot.
module orse_core (
  input  orse_pkg::search_state_t st,
  input  logic [1:0]              func,
  input  logic                    presence,
  input  logic                    id_bit,
  input  logic                    complement_bit,
  input  logic [7:0]              max_roms,
  input  logic [7:0]              retry_limit,
  output orse_pkg::search_state_t st_nxt,
  output orse_pkg::result_t       res
);
  import orse_pkg::*;

  logic [5:0]  pos;
  logic [7:0]  pos_ext;
  logic        dir;
  logic [7:0]  coll_nxt;
  logic [63:0] rom_nxt;
  logic [7:0]  crc_nxt;
  logic [7:0]  found_inc;

  // Pick the direction bit and note a new zero-branch collision
  always_comb begin
    pos      = st.bit_pos;
    pos_ext  = {2'b00, pos};
    coll_nxt = st.last_coll;
    if (!id_bit && !complement_bit) begin
      if (pos_ext < st.prev_coll) begin
        dir = st.have_prev ? st.prev_rom[pos] : 1'b0;
        if (!dir) begin
          coll_nxt = pos_ext;
        end
      end else if (pos_ext == st.prev_coll) begin
        dir = 1'b1;
      end else begin
        dir      = 1'b0;
        coll_nxt = pos_ext;
      end
    end else begin
      dir = id_bit;
    end
    rom_nxt      = st.cur_rom;
    rom_nxt[pos] = dir;
    crc_nxt      = (pos < CRC_END_POS) ? crc_step(st.crc, dir) : st.crc;
    found_inc    = st.found + 8'd1;
  end

  // Advance the search
  always_comb begin
    st_nxt = st;
    res    = '0;
    if (func == FUNC_START) begin
      st_nxt.found     = '0;
      st_nxt.prev_coll = NO_COLL;
      st_nxt.last_coll = NO_COLL;
      st_nxt.have_prev = 1'b0;
      st_nxt.prev_rom  = '0;
      st_nxt.cur_rom   = '0;
      st_nxt.bit_pos   = '0;
      st_nxt.crc       = '0;
      st_nxt.attempts  = retry_limit;
      if (max_roms == 8'd0) begin
        res.status     = ST_OK;
        res.done_res   = 1'b1;
        st_nxt.phase   = PH_IDLE;
      end else begin
        res.issue_reset = 1'b1;
        st_nxt.phase    = PH_RESET;
      end
    end else if (func == FUNC_RESET_DONE && st.phase == PH_RESET) begin
      if (!presence) begin
        res.status   = ST_NO_DEV;
        res.done_res = 1'b1;
        st_nxt.phase = PH_IDLE;
      end else begin
        st_nxt.phase     = PH_BITS;
        st_nxt.bit_pos   = '0;
        st_nxt.cur_rom   = '0;
        st_nxt.crc       = '0;
        st_nxt.last_coll = NO_COLL;
      end
    end else if (func == FUNC_BIT_PAIR && st.phase == PH_BITS) begin
      if (id_bit && complement_bit) begin
        // No device answered the slot: retry or give up
        if (st.attempts == 8'd0) begin
          res.status   = ST_NO_RESP;
          res.done_res = 1'b1;
          st_nxt.phase = PH_IDLE;
        end else begin
          st_nxt.attempts = st.attempts - 8'd1;
          res.issue_reset = 1'b1;
          st_nxt.phase    = PH_RESET;
        end
      end else begin
        res.write_valid  = 1'b1;
        res.write_bit    = dir;
        st_nxt.cur_rom   = rom_nxt;
        st_nxt.crc       = crc_nxt;
        st_nxt.last_coll = coll_nxt;
        if (pos != LAST_POS) begin
          st_nxt.bit_pos = pos + 6'd1;
        end else begin
          st_nxt.bit_pos = '0;
          if (crc_nxt == rom_nxt[63:56]) begin
            // Checked ROM: emit it and set up the next pass
            st_nxt.found     = found_inc;
            res.rom_valid    = 1'b1;
            res.rom_id       = rom_nxt;
            st_nxt.prev_rom  = rom_nxt;
            st_nxt.have_prev = 1'b1;
            st_nxt.prev_coll = coll_nxt;
            st_nxt.attempts  = retry_limit;
            if (coll_nxt == NO_COLL || found_inc >= max_roms) begin
              res.status   = ST_OK;
              res.done_res = 1'b1;
              st_nxt.phase = PH_IDLE;
            end else begin
              res.issue_reset = 1'b1;
              st_nxt.phase    = PH_RESET;
            end
          end else if (st.attempts == 8'd0) begin
            res.status   = ST_CRC_FAIL;
            res.done_res = 1'b1;
            st_nxt.phase = PH_IDLE;
          end else begin
            st_nxt.attempts = st.attempts - 8'd1;
            res.issue_reset = 1'b1;
            st_nxt.phase    = PH_RESET;
          end
          st_nxt.last_coll = NO_COLL;
        end
      end
    end
    res.rom_number = st_nxt.found;
  end

endmodule

// ----- rtl/onewire_rom_search_engine.sv -----
// Path: an accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle while out_stall is low; the input register and the
// result register each hold one beat, so one new beat can still be taken while a result waits downstream.
// The per-slot decision and CRC-8 update are one level of logic between them.
// Reset (rst_n low, synchronous): search idle, max_roms 255, retry_limit 3.
module onewire_rom_search_engine (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_presence,
  input  logic        in_id_bit,
  input  logic        in_complement_bit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic        out_write_bit,
  output logic        out_issue_reset,
  output logic        out_rom_valid,
  output logic [63:0] out_rom_id,
  output logic [7:0]  out_rom_number,
  output logic [2:0]  out_status,
  output logic        out_done_res,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import orse_pkg::*;

  logic          in_valid_r;
  logic [1:0]    func_r;
  logic          presence_r;
  logic          id_bit_r;
  logic          comp_bit_r;
  logic          out_valid_r;
  result_t       res_r;
  result_t       res_nxt;
  search_state_t st_r;
  search_state_t st_nxt;
  logic [7:0]    max_roms_r;
  logic [7:0]    retry_limit_r;
  logic          advance;
  logic          in_take;
  logic          cfg_write;

  orse_core u_core (
    .st             (st_r),
    .func           (func_r),
    .presence       (presence_r),
    .id_bit         (id_bit_r),
    .complement_bit (comp_bit_r),
    .max_roms       (max_roms_r),
    .retry_limit    (retry_limit_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  // Move a beat on when the result register is empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
    if (in_take) begin
      func_r     <= in_func;
      presence_r <= in_presence;
      id_bit_r   <= in_id_bit;
      comp_bit_r <= in_complement_bit;
    end
  end

  // Search state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      st_r.phase      <= PH_IDLE;
      st_r.bit_pos    <= '0;
      st_r.prev_coll  <= NO_COLL;
      st_r.last_coll  <= NO_COLL;
      st_r.cur_rom    <= '0;
      st_r.prev_rom   <= '0;
      st_r.have_prev  <= 1'b0;
      st_r.attempts   <= '0;
      st_r.found      <= '0;
      st_r.crc        <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // Configuration registers
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_roms_r    <= MAX_ROMS_RST;
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_MAX_ROMS:    max_roms_r    <= pwdata[7:0];
        REG_RETRY_LIMIT: retry_limit_r <= pwdata[7:0];
        default:         max_roms_r    <= max_roms_r;
      endcase
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_RETRY_LIMIT) ? retry_limit_r : max_roms_r};

  // Drive the result ports
  assign out_valid       = out_valid_r;
  assign out_write_valid = res_r.write_valid;
  assign out_write_bit   = res_r.write_bit;
  assign out_issue_reset = res_r.issue_reset;
  assign out_rom_valid   = res_r.rom_valid;
  assign out_rom_id      = res_r.rom_id;
  assign out_rom_number  = res_r.rom_number;
  assign out_status      = res_r.status;
  assign out_done_res    = res_r.done_res;

endmodule

// ----- rtl/orse_checker.sv -----
// Port-level checks for the 1-Wire search ROM engine, bound to the top level.
module orse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_write_valid,
  input logic        out_write_bit,
  input logic        out_issue_reset,
  input logic        out_rom_valid,
  input logic [63:0] out_rom_id,
  input logic [2:0]  out_status,
  input logic        out_done_res
);
  import orse_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rom_id) && $stable(out_status))
    else $error("stalled result beat changed");

  // Report a status only when the search ends
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_done_res == (out_status != ST_BUSY)))
    else $error("status and done disagree");

  // Drive a direction bit only with a write request
  a_write_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> !out_write_bit)
    else $error("write bit without write request");

  // Find a ROM only on a bit slot, one that also writes a direction bit
  a_rom_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rom_valid |-> out_write_valid)
    else $error("ROM found outside a bit slot");

  // Keep the identifier zero when no ROM is reported, and never end and retry at once
  a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rom_valid || out_rom_id == 64'd0) && !(out_done_res && out_issue_reset))
    else $error("stray ROM identifier or done with reset request");

endmodule

bind onewire_rom_search_engine orse_checker u_orse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_write_valid (out_write_valid),
  .out_write_bit   (out_write_bit),
  .out_issue_reset (out_issue_reset),
  .out_rom_valid   (out_rom_valid),
  .out_rom_id      (out_rom_id),
  .out_status      (out_status),
  .out_done_res    (out_done_res)
);

// ----- test/onewire_rom_search_engine_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the 1-Wire search ROM engine: simulated bus devices and a predictor.
module onewire_rom_search_engine_test;
  import orse_pkg::*;

  // Request code that the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } req_beat_t;

  // Predicted engine state plus its register copies
  typedef struct {
    logic [1:0]  ph;
    logic [5:0]  slot;
    logic [7:0]  old_fork;
    logic [7:0]  new_fork;
    logic [63:0] rom_acc;
    logic [63:0] last_rom;
    logic        seen_rom;
    logic [7:0]  tries_left;
    logic [7:0]  found;
    logic [7:0]  crc;
    logic [7:0]  rom_cap;
    logic [7:0]  retries;
  } search_model_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic        in_presence = 1'b0;
  logic        in_id_bit = 1'b0;
  logic        in_complement_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_write_valid;
  logic        out_write_bit;
  logic        out_issue_reset;
  logic        out_rom_valid;
  logic [63:0] out_rom_id;
  logic [7:0]  out_rom_number;
  logic [2:0]  out_status;
  logic        out_done_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  req_beat_t     pending[$];
  result_t       results_due[$];
  search_model_t model;
  req_beat_t     cur;
  result_t       want;
  result_t       due;
  int            gap_pct = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            mismatches = 0;
  int            beats_in = 0;
  int            beats_out = 0;
  int            ids_reported = 0;
  int            searches_ended = 0;
  int            settings_run = 0;

  onewire_rom_search_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_presence(in_presence), .in_id_bit(in_id_bit),
    .in_complement_bit(in_complement_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_valid(out_write_valid), .out_write_bit(out_write_bit),
    .out_issue_reset(out_issue_reset), .out_rom_valid(out_rom_valid),
    .out_rom_id(out_rom_id), .out_rom_number(out_rom_number),
    .out_status(out_status), .out_done_res(out_done_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Dallas CRC-8, one bit in, LSB first
  function automatic logic [7:0] crc8_shift(input logic [7:0] c, input logic b);
    return {1'b0, c[7:1]} ^ ((c[0] ^ b) ? CRC_POLY : 8'h00);
  endfunction

  function automatic void end_search(inout search_model_t m, inout result_t r,
                                     input logic [2:0] st);
    r.status = st;
    r.done_res = 1'b1;
    m.ph = PH_IDLE;
  endfunction

  function automatic void retry_or_end(inout search_model_t m, inout result_t r,
                                       input logic [2:0] st);
    if (m.tries_left == 8'd0) begin
      end_search(m, r, st);
    end else begin
      m.tries_left = m.tries_left - 8'd1;
      r.issue_reset = 1'b1;
      m.ph = PH_RESET;
    end
  endfunction

  // Advance the engine by one request beat and produce its result beat
  function automatic void predict_search(inout search_model_t m, input req_beat_t b,
                                         output result_t r);
    logic [5:0] pos;
    logic       dir;
    r = '0;
    pos = m.slot;
    dir = 1'b0;
    if (b.func == FUNC_START) begin
      m.found = '0;
      m.old_fork = NO_COLL;
      m.new_fork = NO_COLL;
      m.seen_rom = 1'b0;
      m.last_rom = '0;
      m.rom_acc = '0;
      m.slot = '0;
      m.crc = '0;
      m.tries_left = m.retries;
      if (m.rom_cap == 8'd0) begin
        end_search(m, r, ST_OK);
      end else begin
        r.issue_reset = 1'b1;
        m.ph = PH_RESET;
      end
    end else if (b.func == FUNC_RESET_DONE && m.ph == PH_RESET) begin
      if (!b.presence) begin
        end_search(m, r, ST_NO_DEV);
      end else begin
        m.ph = PH_BITS;
        m.slot = '0;
        m.rom_acc = '0;
        m.crc = '0;
        m.new_fork = NO_COLL;
      end
    end else if (b.func == FUNC_BIT_PAIR && m.ph == PH_BITS) begin
      if (b.id_bit && b.complement_bit) begin
        retry_or_end(m, r, ST_NO_RESP);
      end else begin
        // Both bits zero: devices disagree here, pick the branch
        if (!b.id_bit && !b.complement_bit) begin
          if ({2'b00, pos} < m.old_fork) begin
            dir = m.seen_rom && m.last_rom[pos];
            if (!dir) m.new_fork = {2'b00, pos};
          end else if ({2'b00, pos} == m.old_fork) begin
            dir = 1'b1;
          end else begin
            m.new_fork = {2'b00, pos};
          end
        end else begin
          dir = b.id_bit;
        end
        r.write_valid = 1'b1;
        r.write_bit = dir;
        m.rom_acc[pos] = dir;
        if (pos < CRC_END_POS) m.crc = crc8_shift(m.crc, dir);
        if (pos != LAST_POS) begin
          m.slot = pos + 6'd1;
        end else begin
          // Last slot: check the CRC byte and close the pass
          m.slot = '0;
          if (m.crc == m.rom_acc[63:56]) begin
            m.found = m.found + 8'd1;
            r.rom_valid = 1'b1;
            r.rom_id = m.rom_acc;
            m.last_rom = m.rom_acc;
            m.seen_rom = 1'b1;
            m.old_fork = m.new_fork;
            m.tries_left = m.retries;
            if (m.new_fork == NO_COLL || m.found >= m.rom_cap) begin
              end_search(m, r, ST_OK);
            end else begin
              r.issue_reset = 1'b1;
              m.ph = PH_RESET;
            end
          end else begin
            retry_or_end(m, r, ST_CRC_FAIL);
          end
          m.new_fork = NO_COLL;
        end
      end
    end
    r.rom_number = m.found;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      report($sformatf("%s expected %h got %h", name, exp_v, got_v));
    end
  endtask

  // Request driver: present queued beats, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_search(model, cur, want);
        results_due.push_back(want);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 && $urandom_range(1, 100) <= gap_pct) begin
          gap_left = $urandom_range(1, 16) - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          in_func <= cur.func;
          in_presence <= cur.presence;
          in_id_bit <= cur.id_bit;
          in_complement_bit <= cur.complement_bit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction, stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (results_due.size() == 0) begin
          report("result beat with no prediction waiting");
        end else begin
          due = results_due.pop_front();
          check_field("write_valid", 64'(due.write_valid), 64'(out_write_valid));
          check_field("write_bit", 64'(due.write_bit), 64'(out_write_bit));
          check_field("issue_reset", 64'(due.issue_reset), 64'(out_issue_reset));
          check_field("rom_valid", 64'(due.rom_valid), 64'(out_rom_valid));
          check_field("rom_id", due.rom_id, out_rom_id);
          check_field("rom_number", 64'(due.rom_number), 64'(out_rom_number));
          check_field("status", 64'(due.status), 64'(out_status));
          check_field("done_res", 64'(due.done_res), 64'(out_done_res));
          if (due.rom_valid) ids_reported++;
          if (due.done_res) searches_ended++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(1, 100) <= gap_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (pending.size() != 0 || results_due.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Write one register, update the predictor copy, read it back
  task automatic write_reg(input logic reg_idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_MAX_ROMS) model.rom_cap = value;
    else model.retries = value;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field($sformatf("register %0d readback", reg_idx), 64'(value), 64'(prdata[7:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_beat(input logic [1:0] f, input logic p, input logic idb,
                            input logic cb);
    pending.push_back({f, p, idb, cb});
  endtask

  // Plan whole searches against a random set of simulated bus devices
  task automatic plan_searches(input int n_beats);
    search_model_t s;
    req_beat_t     b;
    result_t       r;
    logic [63:0]   roms[$];
    logic [63:0]   live[$];
    logic [63:0]   keep[$];
    logic [63:0]   id;
    logic [7:0]    c;
    logic [5:0]    pos;
    logic [1:0]    ph_was;
    logic          bus_id;
    logic          bus_cmp;
    int            n;
    int            n_dev;
    s = model;
    n = 0;
    while (n < n_beats || s.ph != PH_IDLE) begin
      b = 5'($urandom);
      if ($urandom_range(0, 99) < 4) begin
        // noise: any code in any phase
      end else if (s.ph == PH_RESET) begin
        b.func = FUNC_RESET_DONE;
        b.presence = (roms.size() != 0) ^ ($urandom_range(0, 99) < 3);
        // Past the planned length: close the search at its next bus reset
        if (n >= n_beats) b.presence = 1'b0;
      end else if (s.ph == PH_BITS) begin
        // Wired-AND of the devices still on the selected branch
        bus_id = 1'b1;
        bus_cmp = 1'b1;
        foreach (live[i]) begin
          bus_id &= live[i][s.slot];
          bus_cmp &= ~live[i][s.slot];
        end
        b.func = FUNC_BIT_PAIR;
        b.id_bit = bus_id;
        b.complement_bit = bus_cmp;
        if ($urandom_range(0, 99) < 2) {b.id_bit, b.complement_bit} = 2'($urandom);
      end else begin
        // New search on a new device population
        roms.delete();
        n_dev = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 5);
        for (int d = 0; d < n_dev; d++) begin
          if (d > 0 && $urandom_range(0, 1) == 1) begin
            id = roms[$urandom_range(0, d - 1)] ^ (64'd1 << $urandom_range(0, 55));
          end else begin
            id = {$urandom, $urandom};
          end
          c = '0;
          for (int i = 0; i < 56; i++) c = crc8_shift(c, id[i]);
          id[63:56] = ($urandom_range(0, 99) < 8) ? 8'($urandom) : c;
          roms.push_back(id);
        end
        b.func = FUNC_START;
      end
      ph_was = s.ph;
      pos = s.slot;
      predict_search(s, b, r);
      if (ph_was == PH_RESET && s.ph == PH_BITS) live = roms;
      if (r.write_valid) begin
        keep.delete();
        foreach (live[i]) if (live[i][pos] == r.write_bit) keep.push_back(live[i]);
        live = keep;
      end
      pending.push_back(b);
      n++;
    end
  endtask

  initial begin
    static logic [7:0] cap_plan[6]   = '{8'd255, 8'd1, 8'd0, 8'd2, 8'd3, 8'd255};
    static logic [7:0] retry_plan[6] = '{8'd3, 8'd0, 8'd255, 8'd255, 8'd1, 8'd0};
    static int         beats_plan[6] = '{300, 200, 12, 250, 200, 250};
    static int         gap_plan[6]   = '{20, 30, 10, 0, 40, 0};
    model.ph = PH_IDLE;
    model.slot = '0;
    model.old_fork = NO_COLL;
    model.new_fork = NO_COLL;
    model.rom_acc = '0;
    model.last_rom = '0;
    model.seen_rom = 1'b0;
    model.tries_left = '0;
    model.found = '0;
    model.crc = '0;
    model.rom_cap = MAX_ROMS_RST;
    model.retries = RETRY_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored codes, wrong phases, no devices, no response, collisions, restart
    gap_pct = 15;
    queue_beat(FUNC_RESET_DONE, 1'b1, 1'b0, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b0, 1'b0, 1'b0);
    queue_beat(FUNC_UNUSED, 1'b1, 1'b1, 1'b1);
    queue_beat(FUNC_START, 1'b0, 1'b0, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b0, 1'b1, 1'b0);
    queue_beat(FUNC_RESET_DONE, 1'b0, 1'b1, 1'b1);
    queue_beat(FUNC_START, 1'b1, 1'b1, 1'b1);
    queue_beat(FUNC_RESET_DONE, 1'b1, 1'b0, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b0, 1'b1, 1'b1);
    queue_beat(FUNC_RESET_DONE, 1'b1, 1'b0, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b1, 1'b0, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b0, 1'b1, 1'b0);
    queue_beat(FUNC_BIT_PAIR, 1'b1, 1'b0, 1'b1);
    queue_beat(FUNC_RESET_DONE, 1'b1, 1'b1, 1'b0);
    queue_beat(FUNC_UNUSED, 1'b0, 1'b0, 1'b0);
    queue_beat(FUNC_START, 1'b0, 1'b1, 1'b0);
    queue_beat(FUNC_RESET_DONE, 1'b0, 1'b0, 1'b1);
    wait_idle();

    // Random searches under a range of register settings, the last with no idling
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_MAX_ROMS, cap_plan[k]);
      write_reg(REG_RETRY_LIMIT, retry_plan[k]);
      gap_pct = gap_plan[k];
      settings_run++;
      plan_searches(beats_plan[k]);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (results_due.size() != 0) begin
      report($sformatf("%0d predicted results never arrived", results_due.size()));
    end
    $display("Covered %0d request beats and %0d result beats over %0d register settings.",
             beats_in, beats_out, settings_run);
    $display("Searches ended: %0d, ROM ids found: %0d, mismatches: %0d.",
             searches_ended, ids_reported, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #5_000_000;
    $display("Timeout with %0d beats pending and %0d results due.",
             pending.size(), results_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
